### sv/bsb_pkg.sv
package bsb_pkg;

  localparam int MaxDegreeDef = 5;
  localparam int FracBitsDef  = 24;
  localparam int KnotCount    = 7;
  localparam int DegW         = 3;
  localparam int DataW        = 32;
  localparam int DiffW        = 33;
  localparam logic [DegW-1:0] DegReset = 3'd3;

  // register indexes
  localparam logic [0:0] RegDegree = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       init_lvl0;
    logic       div_start;
    logic       div_sel2;
    logic       combine;
    logic [2:0] j;
    logic [2:0] e;
  } bsb_cmd_t;

  typedef struct packed {
    logic div_busy;
  } bsb_sts_t;

endpackage

### sv/bsb_div.sv
module bsb_div import bsb_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DiffW-1:0] num_i,
  input  logic signed [DiffW-1:0] den_i,
  output logic                 busy_o,
  output logic [FRAC_BITS:0]   ratio_o
);

  localparam int MagW = DiffW;
  localparam int CntW = $clog2(FRAC_BITS + 1);

  logic [MagW-1:0]   den_q, den_d;
  logic [MagW:0]     rem_q, rem_d;
  logic [FRAC_BITS:0] quo_q, quo_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;

  logic [MagW-1:0] n_mag, d_mag;
  logic            zero_res, sat_res;
  logic [MagW:0]   rem_sh;

  // magnitudes and trivial cases
  always_comb begin
    n_mag    = num_i[DiffW-1] ? MagW'(-num_i) : MagW'(num_i);
    d_mag    = den_i[DiffW-1] ? MagW'(-den_i) : MagW'(den_i);
    zero_res = (den_i == '0) || (num_i == '0) || (num_i[DiffW-1] != den_i[DiffW-1]);
    sat_res  = n_mag >= d_mag;
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[MagW-1:0], 1'b0};
    if (start_i) begin
      den_d = d_mag;
      rem_d = {1'b0, n_mag};
      cnt_d = CntW'(FRAC_BITS);
      if (zero_res) begin
        quo_d = '0;
      end else if (sat_res) begin
        quo_d = (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else begin
        quo_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[FRAC_BITS-1:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o  = busy_q;
  assign ratio_o = quo_q;

endmodule

### sv/bsb_datapath.sv
module bsb_datapath import bsb_pkg::*; #(
  parameter int MAX_DEGREE = MaxDegreeDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bsb_cmd_t                 cmd_i,
  output bsb_sts_t                 sts_o,
  input  logic [DegW-1:0]          deg_i,
  input  logic signed [DataW-1:0]  x_i,
  input  logic signed [DataW-1:0]  knot_i [KnotCount],
  output logic [FRAC_BITS:0]       value_o
);

  localparam int VW = FRAC_BITS + 1;
  localparam logic [VW-1:0] OneQ = VW'(1) << FRAC_BITS;

  logic signed [DataW-1:0] x_q;
  logic signed [DataW-1:0] k_q [KnotCount];
  logic [VW-1:0]           nv_q [KnotCount];
  logic [VW-1:0]           r1_q;

  logic [2:0]              j1, je, je1;
  logic signed [DiffW-1:0] num, den;
  logic                    div_busy;
  logic [VW-1:0]           ratio;
  logic [2*VW-1:0]         p1, p2;
  logic [VW:0]             sum;
  logic                    in_sup;
  logic [VW-1:0]           new_v;
  logic signed [DiffW-1:0] den2;

  assign j1  = cmd_i.j + 3'd1;
  assign je  = cmd_i.j + cmd_i.e;
  assign je1 = je + 3'd1;

  // divider operands: first or second ratio of the current entry
  always_comb begin
    den2 = DiffW'(k_q[je1]) - DiffW'(k_q[j1]);
    if (cmd_i.div_sel2) begin
      num = DiffW'(x_q) - DiffW'(k_q[j1]);
      den = den2;
    end else begin
      num = DiffW'(x_q) - DiffW'(k_q[cmd_i.j]);
      den = DiffW'(k_q[je]) - DiffW'(k_q[cmd_i.j]);
    end
  end

  bsb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .ratio_o (ratio)
  );

  // combine step: r1 * N(j) + (1 - r2) * N(j+1)
  always_comb begin
    in_sup = (x_q >= k_q[cmd_i.j]) && (x_q < k_q[je1]);
    p1     = r1_q * nv_q[cmd_i.j];
    p2     = (den2 == '0) ? '0 : (OneQ - ratio) * nv_q[j1];
    sum    = (VW+1)'(p1 >> FRAC_BITS) + (VW+1)'(p2 >> FRAC_BITS);
    new_v  = !in_sup ? '0 : (sum > (VW+1)'(OneQ)) ? OneQ : sum[VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_i;
      for (int i = 0; i < KnotCount; i++) k_q[i] <= knot_i[i];
    end
    if (cmd_i.init_lvl0) begin
      for (int i = 0; i < KnotCount - 1; i++)
        nv_q[i] <= ((x_q >= k_q[i]) && (x_q < k_q[i+1])) ? OneQ : '0;
      nv_q[KnotCount-1] <= '0;
    end
    if (cmd_i.div_start && cmd_i.div_sel2) r1_q <= ratio;
    if (cmd_i.combine) nv_q[cmd_i.j] <= new_v;
  end

  assign sts_o.div_busy = div_busy;
  assign value_o        = nv_q[0];

  logic unused;
  assign unused = ^{deg_i, 3'(MAX_DEGREE)};

endmodule

### sv/bsb_ctrl.sv
module bsb_ctrl import bsb_pkg::*; #(
  parameter int MAX_DEGREE = MaxDegreeDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DegW-1:0] degree_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  bsb_sts_t        sts_i,
  output bsb_cmd_t        cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLvl0 = 3'd1;
  localparam logic [2:0] StDiv1 = 3'd2;
  localparam logic [2:0] StDiv2 = 3'd3;
  localparam logic [2:0] StComb = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StWait = 3'd6;

  logic [2:0] st_q, st_d;
  logic [2:0] j_q, j_d, e_q, e_d, deg_q, deg_d;
  logic       sel_q, sel_d;

  // load and level-0 init, then per entry wait for first ratio, then second, and combine; hold result until taken
  always_comb begin
    st_d  = st_q;
    j_d   = j_q;
    e_d   = e_q;
    deg_d = deg_q;
    sel_d = sel_q;
    cmd_o = '0;
    cmd_o.j = j_q;
    cmd_o.e = e_q;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          deg_d = (degree_i > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree_i;
          st_d  = StLvl0;
        end
      end
      StLvl0: begin
        cmd_o.init_lvl0 = 1'b1;
        j_d = 3'd0;
        e_d = 3'd1;
        st_d = (deg_q == 3'd0) ? StOut : StDiv1;
      end
      StDiv1: begin
        cmd_o.div_start = 1'b1;
        sel_d = 1'b0;
        st_d  = StWait;
      end
      StWait: begin
        if (!sts_i.div_busy) st_d = sel_q ? StComb : StDiv2;
      end
      StDiv2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel2  = 1'b1;
        sel_d = 1'b1;
        st_d  = StWait;
      end
      StComb: begin
        cmd_o.combine = 1'b1;
        st_d = StDiv1;
        if (j_q + e_q == deg_q) begin
          j_d = 3'd0;
          if (e_q == deg_q) st_d = StOut;
          else e_d = e_q + 3'd1;
        end else begin
          j_d = j_q + 3'd1;
        end
      end
      StOut: begin
        if (out_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      j_q   <= '0;
      e_q   <= '0;
      deg_q <= '0;
      sel_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      j_q   <= j_d;
      e_q   <= e_d;
      deg_q <= deg_d;
      sel_q <= sel_d;
    end
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);

endmodule

### sv/bspline_basis_cox_de_boor.sv
// Degree 0 needs only the level-0 step; otherwise each of the deg*(deg+1)/2 table entries
// takes two ratio divisions on the bit-serial divider and one combine step.
// One item at a time; the single bit-serial divider serves both ratios of every entry.
// The result stays on the output until taken; the next item is accepted after that.
// Reset (rst_ni low, asynchronous) returns to idle and sets degree to 3.
module bspline_basis_cox_de_boor import bsb_pkg::*; #(
  parameter int MAX_DEGREE = MaxDegreeDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] x_i,
  input  logic signed [DataW-1:0] knot_0_i,
  input  logic signed [DataW-1:0] knot_1_i,
  input  logic signed [DataW-1:0] knot_2_i,
  input  logic signed [DataW-1:0] knot_3_i,
  input  logic signed [DataW-1:0] knot_4_i,
  input  logic signed [DataW-1:0] knot_5_i,
  input  logic signed [DataW-1:0] knot_6_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [24:0]             basis_value_o
);

  logic [DegW-1:0]         degree_q;
  logic signed [DataW-1:0] knots [KnotCount];
  bsb_cmd_t                cmd;
  bsb_sts_t                sts;
  logic [FRAC_BITS:0]      value;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DegReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      degree_q <= pwdata[DegW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? 32'(degree_q) : '0;

  assign knots[0] = knot_0_i;
  assign knots[1] = knot_1_i;
  assign knots[2] = knot_2_i;
  assign knots[3] = knot_3_i;
  assign knots[4] = knot_4_i;
  assign knots[5] = knot_5_i;
  assign knots[6] = knot_6_i;

  bsb_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .degree_i    (degree_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsb_datapath #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .deg_i   (degree_q),
    .x_i     (x_i),
    .knot_i  (knots),
    .value_o (value)
  );

  assign basis_value_o = 25'(value);

endmodule
